>>> design/lrs_pkg.sv
`default_nettype none

package lrs_pkg;

	// Fixed field and register widths.
	localparam int ROW_BITS       = 8;
	localparam int COL_BITS       = 8;
	localparam int GRID_BITS      = 9;
	localparam int SWEEP_BITS     = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_ROWS   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_COLS   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_COUNT = 2'd2;

	// Configuration reset values.
	localparam logic [GRID_BITS-1:0]  GRID_ROWS_RESET   = 9'd189;
	localparam logic [GRID_BITS-1:0]  GRID_COLS_RESET   = 9'd247;
	localparam logic [SWEEP_BITS-1:0] SWEEP_COUNT_RESET = 16'd1000;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Memory read address selection.
	typedef enum logic [2:0] {
		RA_ITEM,
		RA_CENTER,
		RA_NORTH,
		RA_SOUTH,
		RA_WEST,
		RA_EAST
	} raddr_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RUN_INIT,
		ST_CELL_C,
		ST_CELL_N,
		ST_CELL_S,
		ST_CELL_W,
		ST_CELL_E,
		ST_CELL_WB,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		raddr_sel_t raddr_sel;
		logic       item_write;
		logic       load_center;
		logic       acc_load;
		logic       acc_add;
		logic       writeback;
		logic       sweep_init;
		logic       next_col;
		logic       next_row;
		logic       next_sweep;
		logic       load_result;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic run_empty;
		logic last_col;
		logic last_row;
		logic last_sweep;
		logic changed_any;
	} status_t;

endpackage

`default_nettype wire

>>> design/lrs_datapath.sv
`default_nettype none

module lrs_datapath import lrs_pkg::*; #(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_COLS   = 256,
	parameter int VALUE_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic [1:0]                op,
	input  wire logic [ROW_BITS-1:0]       row,
	input  wire logic [COL_BITS-1:0]       col,
	input  wire logic [VALUE_BITS-1:0]     cell_value,
	input  wire logic                      cell_fixed,
	input  wire cmd_t                      cmd,
	output status_t                        stat,
	output logic      [VALUE_BITS-1:0]     read_value,
	output logic                           status
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int RC_W   = $clog2(MAX_ROWS);
	localparam int CC_W   = $clog2(MAX_COLS);
	localparam int RN_W   = RC_W + 1;
	localparam int CN_W   = CC_W + 1;
	localparam int LIM_A  = (RN_W > CN_W) ? RN_W : CN_W;
	localparam int LIM_W  = (LIM_A > GRID_BITS) ? LIM_A : GRID_BITS;
	localparam int ACC_W  = VALUE_BITS + 2;

	// Configuration registers.
	logic [GRID_BITS-1:0]  grid_rows_q;
	logic [GRID_BITS-1:0]  grid_cols_q;
	logic [SWEEP_BITS-1:0] sweep_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q   <= GRID_ROWS_RESET;
			grid_cols_q   <= GRID_COLS_RESET;
			sweep_count_q <= SWEEP_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_ROWS:   grid_rows_q   <= cfg_data[GRID_BITS-1:0];
				CFG_GRID_COLS:   grid_cols_q   <= cfg_data[GRID_BITS-1:0];
				CFG_SWEEP_COUNT: sweep_count_q <= cfg_data[SWEEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Grid size in use, limited to the storage.
	logic [LIM_W-1:0] rows_lim;
	logic [LIM_W-1:0] cols_lim;
	logic [RN_W-1:0]  rows_used;
	logic [CN_W-1:0]  cols_used;

	always_comb begin
		rows_lim = (LIM_W'(grid_rows_q) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
		                                                   : LIM_W'(grid_rows_q);
		cols_lim = (LIM_W'(grid_cols_q) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
		                                                   : LIM_W'(grid_cols_q);
		rows_used = rows_lim[RN_W-1:0];
		cols_used = cols_lim[CN_W-1:0];
	end

	// Captured item.
	op_t                    op_q;
	logic [ROW_BITS-1:0]    row_q;
	logic [COL_BITS-1:0]    col_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic                   fixed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_NONE;
		end else if (cmd.capture) begin
			op_q <= op_t'(op);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q   <= row;
			col_q   <= col;
			value_q <= cell_value;
			fixed_q <= cell_fixed;
		end
	end

	logic              in_grid;
	logic [ADDR_W-1:0] item_addr;

	assign in_grid   = (LIM_W'(row_q) < rows_lim) && (LIM_W'(col_q) < cols_lim);
	assign item_addr = ADDR_W'(row_q * MAX_COLS + col_q);

	// Sweep position counters.
	logic [RC_W-1:0]       r_q;
	logic [CC_W-1:0]       c_q;
	logic [ADDR_W-1:0]     row_base_q;
	logic [ADDR_W-1:0]     center_q;
	logic [SWEEP_BITS-1:0] sweep_q;
	logic                  changed_q;

	always_ff @(posedge clk) begin
		if (cmd.sweep_init || cmd.next_sweep) begin
			r_q        <= RC_W'(1);
			c_q        <= CC_W'(1);
			row_base_q <= ADDR_W'(MAX_COLS);
			center_q   <= ADDR_W'(MAX_COLS + 1);
		end else if (cmd.next_row) begin
			r_q        <= r_q + RC_W'(1);
			c_q        <= CC_W'(1);
			row_base_q <= row_base_q + ADDR_W'(MAX_COLS);
			center_q   <= row_base_q + ADDR_W'(MAX_COLS + 1);
		end else if (cmd.next_col) begin
			c_q      <= c_q + CC_W'(1);
			center_q <= center_q + ADDR_W'(1);
		end
		if (cmd.sweep_init) begin
			sweep_q <= '0;
		end else if (cmd.next_sweep) begin
			sweep_q <= sweep_q + SWEEP_BITS'(1);
		end
	end

	// Cell memory: potential in the low bits, electrode flag on top.
	logic [VALUE_BITS:0] mem [DEPTH];
	logic [VALUE_BITS:0] rdata_q;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [VALUE_BITS:0] mem_wdata;
	logic                mem_we;

	always_comb begin
		case (cmd.raddr_sel)
			RA_CENTER: mem_raddr = center_q;
			RA_NORTH:  mem_raddr = center_q - ADDR_W'(MAX_COLS);
			RA_SOUTH:  mem_raddr = center_q + ADDR_W'(MAX_COLS);
			RA_WEST:   mem_raddr = center_q - ADDR_W'(1);
			RA_EAST:   mem_raddr = center_q + ADDR_W'(1);
			default:   mem_raddr = item_addr;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[mem_raddr];
	end

	// Stencil accumulation over the four neighbor reads.
	logic [VALUE_BITS-1:0] center_val_q;
	logic                  center_fix_q;
	logic [ACC_W-1:0]      acc_q;
	logic [ACC_W-1:0]      sum;
	logic [VALUE_BITS-1:0] new_val;
	logic                  cell_changed;

	always_ff @(posedge clk) begin
		if (cmd.load_center) begin
			center_val_q <= rdata_q[VALUE_BITS-1:0];
			center_fix_q <= rdata_q[VALUE_BITS];
		end
		if (cmd.acc_load) begin
			acc_q <= ACC_W'(rdata_q[VALUE_BITS-1:0]);
		end else if (cmd.acc_add) begin
			acc_q <= sum;
		end
	end

	assign sum          = acc_q + ACC_W'(rdata_q[VALUE_BITS-1:0]);
	assign new_val      = sum[ACC_W-1:2];
	assign cell_changed = !center_fix_q && (new_val != center_val_q);

	// Write port: item writes, or the relaxed cell during a run.
	always_comb begin
		mem_we    = (cmd.item_write && in_grid) || (cmd.writeback && !center_fix_q);
		mem_waddr = cmd.writeback ? center_q : item_addr;
		mem_wdata = cmd.writeback ? {1'b0, new_val} : {fixed_q, value_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (cmd.sweep_init || cmd.next_sweep) begin
			changed_q <= 1'b0;
		end else if (cmd.writeback && cell_changed) begin
			changed_q <= 1'b1;
		end
	end

	// Status toward the controller. The change flag is only looked at in the
	// write-back state, where the current cell's comparison is valid.
	always_comb begin
		stat.op          = op_q;
		stat.run_empty   = (rows_used < RN_W'(3)) || (cols_used < CN_W'(3))
		                   || (sweep_count_q == '0);
		stat.last_col    = (CN_W'(c_q) + CN_W'(2)) == cols_used;
		stat.last_row    = (RN_W'(r_q) + RN_W'(2)) == rows_used;
		stat.last_sweep  = ((SWEEP_BITS + 1)'(sweep_q) + (SWEEP_BITS + 1)'(1))
		                   == (SWEEP_BITS + 1)'(sweep_count_q);
		stat.changed_any = changed_q || cell_changed;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			read_value <= (op_q == OP_READ && in_grid) ? rdata_q[VALUE_BITS-1:0] : '0;
			status     <= (op_q == OP_WRITE || op_q == OP_READ) && !in_grid;
		end
	end

endmodule

`default_nettype wire

>>> design/lrs_ctrl.sv
`default_nettype none

module lrs_ctrl import lrs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    out_stall,
	input  wire status_t stat,
	output cmd_t         cmd,
	output logic         in_stall,
	output logic         out_valid
);

	state_t state_q;
	state_t state_d;
	logic   slot_free;

	// The result slot can take a new item when empty or being emptied.
	assign slot_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = (stat.op == OP_RUN) ? ST_RUN_INIT : ST_RESP;
			end
			ST_RUN_INIT: begin
				state_d = stat.run_empty ? ST_RESP : ST_CELL_C;
			end
			ST_CELL_C: state_d = ST_CELL_N;
			ST_CELL_N: state_d = ST_CELL_S;
			ST_CELL_S: state_d = ST_CELL_W;
			ST_CELL_W: state_d = ST_CELL_E;
			ST_CELL_E: state_d = ST_CELL_WB;
			ST_CELL_WB: begin
				if (!stat.last_col || !stat.last_row) begin
					state_d = ST_CELL_C;
				end else if (stat.last_sweep || !stat.changed_any) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_CELL_C;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd           = '0;
		cmd.raddr_sel = RA_ITEM;
		in_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_DISPATCH: begin
				cmd.item_write = (stat.op == OP_WRITE);
			end
			ST_RUN_INIT: begin
				cmd.sweep_init = !stat.run_empty;
			end
			ST_CELL_C: begin
				cmd.raddr_sel = RA_CENTER;
			end
			ST_CELL_N: begin
				cmd.raddr_sel   = RA_NORTH;
				cmd.load_center = 1'b1;
			end
			ST_CELL_S: begin
				cmd.raddr_sel = RA_SOUTH;
				cmd.acc_load  = 1'b1;
			end
			ST_CELL_W: begin
				cmd.raddr_sel = RA_WEST;
				cmd.acc_add   = 1'b1;
			end
			ST_CELL_E: begin
				cmd.raddr_sel = RA_EAST;
				cmd.acc_add   = 1'b1;
			end
			ST_CELL_WB: begin
				cmd.raddr_sel = RA_CENTER;
				cmd.writeback = 1'b1;
				if (!stat.last_col) begin
					cmd.next_col = 1'b1;
				end else if (!stat.last_row) begin
					cmd.next_row = 1'b1;
				end else if (!stat.last_sweep && stat.changed_any) begin
					cmd.next_sweep = 1'b1;
				end
			end
			ST_RESP: begin
				cmd.load_result = slot_free;
			end
			default: ;
		endcase
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> design/laplace_relaxation_sweep.sv
`default_nettype none

// Grid potential solver with in-place Gauss-Seidel relaxation of the five-point
// Laplace stencil over a MAX_ROWS x MAX_COLS cell memory (UQ2.14 potentials
// plus an electrode flag per cell). Every item gives one result. A write or a
// read item is accepted, dispatched and its result loaded into the output
// register; the next item is accepted while a result still waits. A run item
// relaxes each interior cell once per sweep, for up to sweep_count sweeps; a
// run ends after the first sweep that changes no cell. Per cell, the single
// read port of the cell memory fetches the center cell and its four neighbors
// one after another before the write back. The memory has no reset and no
// clearing pass: every cell in use must be written before a run or a read.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce this.
module laplace_relaxation_sweep import lrs_pkg::*; #(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_COLS   = 256,
	parameter int VALUE_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                op,
	input  wire logic [ROW_BITS-1:0]       row,
	input  wire logic [COL_BITS-1:0]       col,
	input  wire logic [VALUE_BITS-1:0]     cell_value,
	input  wire logic                      cell_fixed,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [VALUE_BITS-1:0]     read_value,
	output logic                           status
);

	cmd_t    cmd;
	status_t stat;

	lrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	lrs_datapath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.row        (row),
		.col        (col),
		.cell_value (cell_value),
		.cell_fixed (cell_fixed),
		.cmd        (cmd),
		.stat       (stat),
		.read_value (read_value),
		.status     (status)
	);

	// An accepted item stalls the input in the cycle after its acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on two consecutive cycles");

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> !out_valid || !out_stall)
		else $error("result loaded over a stalled result");

	// An out-of-grid report always carries a zero value.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_value == '0)
		else $error("error status with nonzero read value");

	// Memory write back happens only inside a run, never with an item write.
	a_write_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.writeback |-> !cmd.item_write && !cmd.capture && in_stall)
		else $error("write back overlaps item handling");

endmodule

`default_nettype wire
